FILE: design/assert_macros.svh
// Assertion helper macros shared by the fragmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, held off while reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

FILE: design/nalfu_pkg.sv
// Package: shared constants and types of the NAL unit FU fragmenter.
`timescale 1ns / 1ps
package nalfu_pkg;

  localparam int unsigned LenW       = 16;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = 3;
  localparam int unsigned IdxW       = 2;

  localparam logic [LenW-1:0] MaxUnitBytes   = 16'd65535;
  localparam logic [LenW-1:0] MinPacketBytes = 16'd4;
  localparam logic [LenW-1:0] ResetMaxPacket = 16'd1400;

  // Header construction constants.
  localparam logic [7:0] NriMaskH264  = 8'hE0;
  localparam logic [7:0] FuTypeH264   = 8'd28;
  localparam logic [7:0] FuStartBit   = 8'h80;
  localparam logic [7:0] TypeMaskH264 = 8'h1F;
  localparam logic [7:0] TypeMaskH265 = 8'h7E;
  localparam logic [7:0] KeepMaskH265 = 8'h81;
  localparam logic [7:0] FuTypeH265   = 8'(49 << 1);
  localparam logic [7:0] FuEndBit     = 8'h40;

  // Configuration register indexes.
  localparam logic CfgCodecSelect   = 1'b0;
  localparam logic CfgMaxPacketSize = 1'b1;

  typedef struct packed {
    logic            codec_select;
    logic [LenW-1:0] max_packet_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [LenW-1:0] unit_length;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]                 count;
    logic [MaxResults-1:0][7:0]      data;
    logic [MaxResults-1:0]           pkt_end;
    logic [MaxResults-1:0]           done;
  } res_t;

endpackage

FILE: design/nalfu_engine.sv
// Per-item fragmentation logic and unit state registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nalfu_engine import nalfu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] bip_q, bip_d;
  logic            frag_q, frag_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [7:0]      fu_q, fu_d;
  logic [LenW-1:0] raw_q, raw_d;
  logic [LenW-1:0] eff_q, eff_d;
  logic [LenW-1:0] max_q, max_d;
  logic            codec_q, codec_d;

  logic [LenW-1:0] len1;
  logic [LenW-1:0] hdr;
  logic [LenW:0]   idx_inc;
  logic [LenW:0]   bip_inc;
  logic [LenW:0]   tail_sum;
  logic            last;
  logic            pe;
  logic [7:0]      fu_out;
  logic [CntW-1:0] n;
  logic [7:0]      b;

  always_comb begin
    idx_d    = idx_q;
    bip_d    = bip_q;
    frag_d   = frag_q;
    first_d  = first_q;
    second_d = second_q;
    fu_d     = fu_q;
    raw_d    = raw_q;
    eff_d    = eff_q;
    max_d    = max_q;
    codec_d  = codec_q;
    res_o    = '0;
    n        = '0;
    last     = 1'b0;
    pe       = 1'b0;
    fu_out   = '0;
    bip_inc  = '0;
    tail_sum = '0;
    b        = item_i.data_byte;
    len1     = (item_i.unit_length == '0) ? LenW'(1) : item_i.unit_length;

    // Latch length, packet limit and codec on the first byte of a unit.
    if (idx_q == '0) begin
      raw_d   = len1;
      eff_d   = (len1 < MaxUnitBytes) ? len1 : MaxUnitBytes;
      max_d   = (cfg_i.max_packet_bytes < MinPacketBytes) ? MinPacketBytes
                                                          : cfg_i.max_packet_bytes;
      codec_d = cfg_i.codec_select;
      frag_d  = eff_d > max_d;
      bip_d   = '0;
    end
    hdr     = codec_d ? LenW'(3) : LenW'(2);
    idx_inc = {1'b0, idx_q} + (LenW+1)'(1);

    if (idx_q < eff_d) begin
      last = (idx_inc == {1'b0, eff_d});
      if (!frag_d) begin
        bip_inc = {1'b0, bip_d} + (LenW+1)'(1);
        bip_d   = last ? '0 : bip_inc[LenW-1:0];
        res_o.data[n[IdxW-1:0]]    = b;
        res_o.pkt_end[n[IdxW-1:0]] = last;
        res_o.done[n[IdxW-1:0]]    = last;
        n = n + CntW'(1);
      end else if (!codec_d && idx_q == '0) begin
        first_d = (b & NriMaskH264) | FuTypeH264;
        fu_d    = b & TypeMaskH264;
        res_o.data[n[IdxW-1:0]] = first_d;
        n = n + CntW'(1);
        res_o.data[n[IdxW-1:0]] = FuStartBit | fu_d;
        n = n + CntW'(1);
        bip_d = LenW'(2);
      end else if (codec_d && idx_q == '0) begin
        // Withhold everything until the second header byte is known.
        first_d = (b & KeepMaskH265) | FuTypeH265;
        fu_d    = (b & TypeMaskH265) >> 1;
      end else if (codec_d && idx_q == LenW'(1)) begin
        second_d = b;
        res_o.data[n[IdxW-1:0]] = first_d;
        n = n + CntW'(1);
        res_o.data[n[IdxW-1:0]] = second_d;
        n = n + CntW'(1);
        res_o.data[n[IdxW-1:0]] = FuStartBit | fu_d;
        n = n + CntW'(1);
        bip_d = LenW'(3);
      end else begin
        if (bip_d == '0) begin
          // New fragment: repeat headers, mark end if the rest fits.
          tail_sum = {1'b0, hdr} + {1'b0, eff_d - idx_q};
          fu_out   = (tail_sum <= {1'b0, max_d}) ? (fu_d | FuEndBit) : fu_d;
          res_o.data[n[IdxW-1:0]] = first_d;
          n = n + CntW'(1);
          if (codec_d) begin
            res_o.data[n[IdxW-1:0]] = second_d;
            n = n + CntW'(1);
          end
          res_o.data[n[IdxW-1:0]] = fu_out;
          n = n + CntW'(1);
          bip_d = hdr;
        end
        bip_inc = {1'b0, bip_d} + (LenW+1)'(1);
        pe      = last || (bip_inc >= {1'b0, max_d});
        bip_d   = pe ? '0 : bip_inc[LenW-1:0];
        res_o.data[n[IdxW-1:0]]    = b;
        res_o.pkt_end[n[IdxW-1:0]] = pe;
        res_o.done[n[IdxW-1:0]]    = last;
        n = n + CntW'(1);
      end
    end

    // Advance the byte index; wrap at the raw unit length.
    if (idx_inc >= {1'b0, raw_d}) begin
      idx_d  = '0;
      bip_d  = '0;
      frag_d = 1'b0;
    end else begin
      idx_d = idx_inc[LenW-1:0];
    end
    res_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      bip_q    <= '0;
      frag_q   <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
      fu_q     <= '0;
      raw_q    <= '0;
      eff_q    <= '0;
      max_q    <= MinPacketBytes;
      codec_q  <= 1'b0;
    end else if (fire_i) begin
      idx_q    <= idx_d;
      bip_q    <= bip_d;
      frag_q   <= frag_d;
      first_q  <= first_d;
      second_q <= second_d;
      fu_q     <= fu_d;
      raw_q    <= raw_d;
      eff_q    <= eff_d;
      max_q    <= max_d;
      codec_q  <= codec_d;
    end
  end

  `ASSERT_IMPL(a_idx_in_unit, clk_i, rst_ni, idx_q != '0, idx_q < raw_q,
               "byte index ran past the unit length")
  `ASSERT_IMPL(a_frag_fill, clk_i, rst_ni, frag_q, bip_q < max_q,
               "fragment fill reached the packet limit without closing")

endmodule

FILE: design/nalfu_obuf.sv
// Result buffer: holds up to four result bytes of one item and hands them out in order.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nalfu_obuf import nalfu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       packet_end_o,
  output logic       unit_done_o
);

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [IdxW-1:0]            rd_q, rd_d;
  logic [MaxResults-1:0][7:0] data_q;
  logic [MaxResults-1:0]      pe_q;
  logic [MaxResults-1:0]      done_q;
  logic                       take;

  assign out_valid_o  = cnt_q != '0;
  assign take         = out_valid_o && !out_stall_i;
  // Free when empty, or when the last pending item leaves this cycle.
  assign free_o       = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !out_stall_i);
  assign out_byte_o   = data_q[rd_q];
  assign packet_end_o = pe_q[rd_q];
  assign unit_done_o  = done_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = res_i.count;
      rd_d  = '0;
    end else if (take) begin
      cnt_d = cnt_q - CntW'(1);
      rd_d  = rd_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
      pe_q   <= res_i.pkt_end;
      done_q <= res_i.done;
    end
  end

  `ASSERT_AT(a_rd_in_range, clk_i, rst_ni,
             ({1'b0, rd_q} + cnt_q) <= CntW'(MaxResults),
             "read pointer and pending count exceed the buffer")

endmodule

FILE: design/nal_unit_fu_fragmenter_unit.sv
// Top level of the NAL unit FU fragmenter: input register, engine, result buffer, config.
`timescale 1ns / 1ps
// RTP FU fragmenter for H.264 / H.265 NAL units. One NAL byte enters per item, tagged with
// the unit length; result bytes leave with packet_end and unit_done flags, one per cycle
// while out_stall_i is low. A byte that yields zero or one result byte does not hold the
// input, so plain payload streams at full rate while the output is not stalled. A byte
// that opens a fragment also yields its headers (up to four result bytes) and holds the
// input while the single output port drains the four-entry result buffer. An accepted
// byte passes the input register, then the result buffer. Configuration writes are
// always taken (cfg_ready_o is high) and apply from the next unit's first byte.
module nal_unit_fu_fragmenter_unit import nalfu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic [LenW-1:0] unit_length_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            packet_end_o,
  output logic            unit_done_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [LenW-1:0] cfg_data_i
);

  logic  in_vld_q, in_vld_d;
  item_t item_q;
  cfg_t  cfg_q, cfg_d;
  res_t  res;
  logic  free;
  logic  fire;
  logic  in_take;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_vld_q && free;
  assign in_stall_o  = in_vld_q && !free;
  assign in_take     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCodecSelect:   cfg_d.codec_select     = cfg_data_i[0];
        CfgMaxPacketSize: cfg_d.max_packet_bytes = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q               <= 1'b0;
      cfg_q.codec_select     <= 1'b0;
      cfg_q.max_packet_bytes <= ResetMaxPacket;
    end else begin
      in_vld_q <= in_vld_d;
      cfg_q    <= cfg_d;
    end
  end

  // Hold the input payload until the engine consumes it.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.data_byte   <= data_byte_i;
      item_q.unit_length <= unit_length_i;
    end
  end

  nalfu_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  nalfu_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .res_i        (res),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .unit_done_o  (unit_done_o)
  );

endmodule

FILE: bench/nal_unit_fu_fragmenter_unit_test.sv
// Self-checking testbench for the NAL unit FU fragmenter: queued NAL bytes, predicted payload.
`timescale 1ns / 1ps
module nal_unit_fu_fragmenter_unit_test;
  import nalfu_pkg::*;

  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;
  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       pkt_end;
    logic       done;
  } payload_byte_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [7:0]      data_byte_i = '0;
  logic [LenW-1:0] unit_length_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      out_byte_o;
  logic            packet_end_o;
  logic            unit_done_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = 1'b0;
  logic [LenW-1:0] cfg_data_i = '0;

  nal_unit_fu_fragmenter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .unit_length_i (unit_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .packet_end_o  (packet_end_o),
    .unit_done_o   (unit_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  item_t         nal_bytes_q[$];
  payload_byte_t payload_q[$];

  int unsigned items_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned units_queued = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  int unsigned feed_pause = 0;
  int unsigned feed_calm = 0;
  int unsigned sink_pause = 0;
  int unsigned sink_calm = 0;
  int unsigned hold_left = 0;
  bit          hold_spent = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          gentle = 1'b0;

  // Shadow registers and the fragmenter's own state.
  logic            codec_reg = CODEC_H264;
  logic [LenW-1:0] max_pkt_reg = ResetMaxPacket;
  int unsigned     nal_pos = 0;
  int unsigned     pkt_fill = 0;
  bit              frag_on = 1'b0;
  logic [7:0]      hdr0 = '0;
  logic [7:0]      hdr1 = '0;
  logic [7:0]      fu_hdr = '0;
  int unsigned     len_raw = 0;
  int unsigned     len_eff = 0;
  int unsigned     lim = 4;
  logic            codec_unit = CODEC_H264;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void push_payload(input logic [7:0] v, input logic pe, input logic dn);
    payload_q.push_back('{value: v, pkt_end: pe, done: dn});
  endfunction

  // Work out the payload bytes that one accepted NAL byte releases.
  function automatic void predict_payload(input logic [7:0] b, input logic [LenW-1:0] tag);
    int unsigned hdr_len;
    logic [7:0]  fu;
    bit          last_b;
    bit          pe;
    if (nal_pos == 0) begin
      len_raw = (tag == 0) ? 1 : tag;
      len_eff = (len_raw < MaxUnitBytes) ? len_raw : MaxUnitBytes;
      lim = (max_pkt_reg < MinPacketBytes) ? MinPacketBytes : max_pkt_reg;
      codec_unit = codec_reg;
      frag_on = len_eff > lim;
      pkt_fill = 0;
    end
    hdr_len = (codec_unit == CODEC_H265) ? 3 : 2;
    if (nal_pos < len_eff) begin
      last_b = (nal_pos + 1 == len_eff);
      if (!frag_on) begin
        push_payload(b, last_b, last_b);
      end else if (codec_unit == CODEC_H264 && nal_pos == 0) begin
        hdr0 = (b & NriMaskH264) | FuTypeH264;
        fu_hdr = b & TypeMaskH264;
        push_payload(hdr0, 1'b0, 1'b0);
        push_payload(FuStartBit | fu_hdr, 1'b0, 1'b0);
        pkt_fill = 2;
      end else if (codec_unit == CODEC_H265 && nal_pos == 0) begin
        // hold the headers until the second NAL header byte is in
        hdr0 = (b & KeepMaskH265) | FuTypeH265;
        fu_hdr = (b & TypeMaskH265) >> 1;
      end else if (codec_unit == CODEC_H265 && nal_pos == 1) begin
        hdr1 = b;
        push_payload(hdr0, 1'b0, 1'b0);
        push_payload(hdr1, 1'b0, 1'b0);
        push_payload(FuStartBit | fu_hdr, 1'b0, 1'b0);
        pkt_fill = 3;
      end else begin
        if (pkt_fill == 0) begin
          fu = fu_hdr;
          if (hdr_len + (len_eff - nal_pos) <= lim) fu = fu | FuEndBit;
          push_payload(hdr0, 1'b0, 1'b0);
          if (hdr_len == 3) push_payload(hdr1, 1'b0, 1'b0);
          push_payload(fu, 1'b0, 1'b0);
          pkt_fill = hdr_len;
        end
        pkt_fill++;
        pe = last_b || (pkt_fill >= lim);
        push_payload(b, pe, last_b);
        if (pe) pkt_fill = 0;
      end
    end
    nal_pos++;
    if (nal_pos >= len_raw) begin
      nal_pos = 0;
      pkt_fill = 0;
      frag_on = 1'b0;
    end
  endfunction

  function automatic int unsigned next_pause(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(15, 60);
    if (r < 55) return 0;
    if (r < 88 || gentle) return $urandom_range(1, gentle ? 1 : 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : feed
    bit    take;
    item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= '0;
      unit_length_i <= '0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        predict_payload(data_byte_i, unit_length_i);
        items_taken++;
      end
      if (in_valid_i && !take) begin
        // hold the stalled item
      end else if (feed_pause != 0) begin
        in_valid_i <= 1'b0;
        feed_pause = feed_pause - 1;
      end else if (nal_bytes_q.size() != 0) begin
        nxt = nal_bytes_q.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= nxt.data_byte;
        unit_length_i <= nxt.unit_length;
        feed_pause = next_pause(feed_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : sink
    payload_byte_t want;
    bit            bad;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        bytes_checked++;
        if (payload_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: payload byte with nothing expected: expected none, actual %h/%b/%b",
                     $time, out_byte_o, packet_end_o, unit_done_o);
        end else begin
          want = payload_q.pop_front();
          bad = 1'b0;
          if (out_byte_o !== want.value) begin
            bad = 1'b1;
            if (mismatches < MAX_REPORTS)
              $display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte_o);
          end
          if (packet_end_o !== want.pkt_end) begin
            bad = 1'b1;
            if (mismatches < MAX_REPORTS)
              $display("%0t: packet_end expected %b actual %b", $time, want.pkt_end,
                       packet_end_o);
          end
          if (unit_done_o !== want.done) begin
            bad = 1'b1;
            if (mismatches < MAX_REPORTS)
              $display("%0t: unit_done expected %b actual %b", $time, want.done, unit_done_o);
          end
          if (bad) mismatches++;
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (sink_pause != 0) begin
        out_stall_i <= 1'b1;
        sink_pause = sink_pause - 1;
      end else begin
        out_stall_i <= 1'b0;
        sink_pause = next_pause(sink_calm);
      end
    end
  end

  // Long receiver hold-off so that the block backs up onto its input.
  always @(posedge clk_i or negedge rst_ni) begin : squeeze
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (squeeze_req && !hold_spent) begin
      hold_left <= SQUEEZE_CYCLES;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d payload bytes still awaited", cycle_count,
               payload_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic idx, input logic [LenW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgCodecSelect) codec_reg = val[0];
    else max_pkt_reg = val;
    cfg_writes++;
  endtask

  task automatic set_config(input logic codec, input logic [LenW-1:0] maxp);
    cfg_write(CfgCodecSelect, {{(LenW-1){1'b0}}, codec});
    cfg_write(CfgMaxPacketSize, maxp);
  endtask

  // Queue bytes [from, to) of a unit; retag scrambles the length tag on later bytes.
  task automatic queue_bytes(input logic [LenW-1:0] tag, input logic [7:0] head,
                             input int unsigned from, input int unsigned to, input bit retag);
    item_t it;
    if (from == 0) units_queued++;
    for (int unsigned k = from; k < to; k++) begin
      it.data_byte = (k == 0) ? head : 8'($urandom_range(0, 255));
      it.unit_length = tag;
      if (k != 0 && retag && $urandom_range(0, 3) == 0)
        it.unit_length = LenW'($urandom_range(0, 65535));
      nal_bytes_q.push_back(it);
    end
  endtask

  task automatic queue_unit(input logic [LenW-1:0] tag, input logic [7:0] head, input bit retag);
    queue_bytes(tag, head, 0, (tag == 0) ? 1 : tag, retag);
  endtask

  // Wait for every item to go in and every payload byte to come out.
  task automatic settle();
    while (nal_bytes_q.size() != 0 || in_valid_i || payload_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned     len;
    int unsigned     eff_lim;
    int unsigned     queued;
    int unsigned     r;
    logic [LenW-1:0] maxp;
    logic            codec;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: single-byte unit and a zero length tag.
    queue_unit(16'd1, 8'hFF, 1'b0);
    queue_unit(16'd0, 8'h00, 1'b0);
    settle();

    // Packet limit below the floor; exact fit, then one byte over.
    set_config(CODEC_H264, 16'd0);
    queue_unit(16'd4, 8'h65, 1'b0);
    queue_unit(16'd5, 8'hFF, 1'b1);
    settle();
    set_config(CODEC_H265, 16'd3);
    queue_unit(16'd6, 8'h00, 1'b1);
    settle();

    // Register writes half way through a unit apply from the next one.
    set_config(CODEC_H264, 16'd4);
    queue_bytes(16'd8, 8'hFE, 0, 4, 1'b0);
    settle();
    set_config(CODEC_H265, 16'hFFFF);
    queue_bytes(16'd8, 8'hFE, 4, 8, 1'b0);
    queue_unit(16'd3, 8'h81, 1'b0);
    settle();

    // Near-top packet limit: the unit passes through as one packet.
    gentle = 1'b1;
    set_config(CODEC_H265, 16'hFFFE);
    queue_unit(16'd40, 8'h7E, 1'b1);
    settle();
    gentle = 1'b0;

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin codec = CODEC_H264; maxp = 16'd4; end
        1: begin codec = CODEC_H265; maxp = LenW'($urandom_range(0, 3)); end
        2: begin codec = 1'($urandom_range(0, 1)); maxp = 16'hFFFF; end
        3: begin codec = CODEC_H265; maxp = LenW'($urandom_range(5, 12)); end
        default: begin codec = 1'($urandom_range(0, 1)); maxp = LenW'($urandom_range(4, 24)); end
      endcase
      set_config(codec, maxp);
      eff_lim = (maxp < MinPacketBytes) ? MinPacketBytes : maxp;
      queued = 0;
      while (queued < 34) begin
        r = $urandom_range(0, 99);
        if (r < 65) len = $urandom_range(1, 30);
        else if (r < 80) len = $urandom_range(31, 80);
        else if (r < 95) len = (eff_lim <= 60) ? $urandom_range(eff_lim - 1, eff_lim + 2)
                                               : $urandom_range(1, 40);
        else len = 0;
        queue_unit(LenW'(len), 8'($urandom_range(0, 255)), 1'b1);
        queued += (len == 0) ? 1 : len;
      end
      if (ph == 3) squeeze_req = 1'b1;
      settle();
    end

    $display("Run covered %0d NAL bytes in %0d units and %0d register writes,", items_taken,
             units_queued, cfg_writes);
    $display("both codecs, packet limits from below the floor to the top; %0d payload bytes checked.",
             bytes_checked);
    if (mismatches == 0 && payload_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
